/* rtl/gnv_pkg.sv */
// Shared types, constants and tables of the gauge needle vertex generator.
`default_nettype none
package gnv_pkg;

  localparam int SINE_FRAC_BITS = 14;
  localparam int COORD_BITS     = 14;

  localparam int SIN_MAG_W = SINE_FRAC_BITS + 1;
  localparam int SIN_W     = SINE_FRAC_BITS + 2;
  localparam int LEN_W     = 10;
  localparam int PROD_W    = SIN_W + LEN_W + 1;
  localparam int POS_W     = COORD_BITS + 4;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef logic [8:0]                  ang_t;
  typedef logic signed [9:0]           off_t;
  typedef logic [2:0]                  vidx_t;
  typedef logic [LEN_W-1:0]            len_t;
  typedef logic signed [SIN_W-1:0]     sin_t;
  typedef logic [SIN_MAG_W-1:0]        sin_mag_t;
  typedef sin_mag_t                    sin_tab_t [0:90];

  typedef enum logic [2:0] {
    REG_CENTER_X, REG_CENTER_Y, REG_RADIUS, REG_START_ANGLE,
    REG_ANGLE_SPAN, REG_FULL_SCALE, REG_NEEDLE_STYLE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    STYLE_KITE, STYLE_SPEAR, STYLE_ARROW, STYLE_BAR, STYLE_BAR_TIP,
    STYLE_DIAMOND, STYLE_DIAMOND_WIDE
  } style_t;

  typedef enum logic [3:0] {
    LEN_ZERO, LEN_FULL, LEN_32TH, LEN_3Q, LEN_3Q_16TH, LEN_31_32,
    LEN_HALF, LEN_15_16, LEN_QUARTER, LEN_TWO, LEN_FIVE
  } len_sel_t;

  typedef struct packed {
    logic [11:0]        center_x;
    logic [11:0]        center_y;
    len_t               radius;
    logic signed [9:0]  start_angle;
    logic [8:0]         angle_span;
    logic [15:0]        full_scale;
    logic [2:0]         needle_style;
  } gnv_cfg_t;

  typedef struct packed {
    off_t     off1;
    len_sel_t len1;
    off_t     off2;
    len_sel_t len2;
  } vtx_op_t;

  // Q30 Taylor series per degree, rounded half up to the table precision
  function automatic sin_tab_t build_sin_tab();
    localparam longint unsigned TDIV [1:8] = '{6, 20, 42, 72, 110, 156, 210, 272};
    sin_tab_t        tab;
    longint unsigned x, x2, t;
    longint          sum;
    for (int d = 0; d <= 90; d++) begin
      x   = (longint'(d) * PI_Q30 + 64'd90) / 64'd180;
      x2  = (x * x) >> 30;
      t   = x;
      sum = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        t = ((t * x2) >> 30) / TDIV[k];
        if (k % 2 == 1) sum = sum - longint'(t);
        else sum = sum + longint'(t);
      end
      if (sum < 0) sum = 0;
      sum = (sum + (longint'(1) << (29 - SINE_FRAC_BITS))) >>> (30 - SINE_FRAC_BITS);
      tab[d] = sin_mag_t'(sum);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // base angle 0..359 plus offset -90..360, back into 0..359
  function automatic ang_t wrap_small(ang_t b, off_t off);
    logic signed [11:0] s;
    s = $signed({3'b000, b}) + 12'(off);
    if (s < 0) s = s + 12'sd360;
    else if (s >= 12'sd360) s = s - 12'sd360;
    return s[8:0];
  endfunction

  function automatic sin_t sine_deg(ang_t d);
    logic [6:0] idx;
    logic       neg;
    sin_t       m;
    neg = 1'b0;
    if (d <= 9'd90) idx = d[6:0];
    else if (d <= 9'd180) idx = 7'(9'd180 - d);
    else if (d <= 9'd270) begin
      idx = 7'(d - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - d);
      neg = 1'b1;
    end
    m = sin_t'(SIN_TAB[idx]);
    return neg ? -m : m;
  endfunction

  function automatic len_t len_value(len_sel_t sel, len_t r);
    len_t         r34;
    logic [13:0]  r15;
    len_t         v;
    r34 = r - (r >> 2);
    r15 = {4'b0000, r} * 14'd15;
    case (sel)
      LEN_FULL:    v = r;
      LEN_32TH:    v = r >> 5;
      LEN_3Q:      v = r34;
      LEN_3Q_16TH: v = r34 + (r >> 4);
      LEN_31_32:   v = r - (r >> 5);
      LEN_HALF:    v = r - (r >> 1);
      LEN_15_16:   v = len_t'(r15 >> 4);
      LEN_QUARTER: v = r >> 2;
      LEN_TWO:     v = len_t'(2);
      LEN_FIVE:    v = len_t'(5);
      default:     v = '0;
    endcase
    return v;
  endfunction

  function automatic vidx_t vtx_count(logic [2:0] style);
    vidx_t n;
    case (style_t'(style))
      STYLE_KITE, STYLE_SPEAR, STYLE_DIAMOND, STYLE_DIAMOND_WIDE: n = 3'd5;
      STYLE_ARROW, STYLE_BAR, STYLE_BAR_TIP:                      n = 3'd7;
      default:                                                    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic vtx_op_t mk_op(int o1, len_sel_t l1, int o2, len_sel_t l2);
    vtx_op_t op;
    op.off1 = off_t'(o1);
    op.len1 = l1;
    op.off2 = off_t'(o2);
    op.len2 = l2;
    return op;
  endfunction

  // Each vertex is the pivot plus up to two floored displacements
  function automatic vtx_op_t vtx_op(logic [2:0] style, vidx_t k);
    vtx_op_t op;
    op = mk_op(0, LEN_ZERO, 0, LEN_ZERO);
    case (style_t'(style))
      STYLE_KITE: begin
        case (k)
          3'd0: op = mk_op(0, LEN_FULL, 0, LEN_ZERO);
          3'd1: op = mk_op(90, LEN_32TH, 0, LEN_ZERO);
          3'd2: op = mk_op(180, LEN_32TH, 0, LEN_ZERO);
          3'd3: op = mk_op(270, LEN_32TH, 0, LEN_ZERO);
          default: ;
        endcase
      end
      STYLE_SPEAR: begin
        case (k)
          3'd0: op = mk_op(0, LEN_FULL, 0, LEN_ZERO);
          3'd1: op = mk_op(4, LEN_3Q, 0, LEN_ZERO);
          3'd3: op = mk_op(-4, LEN_3Q, 0, LEN_ZERO);
          default: ;
        endcase
      end
      STYLE_ARROW: begin
        case (k)
          3'd0: op = mk_op(0, LEN_FULL, 0, LEN_ZERO);
          3'd1: op = mk_op(6, LEN_3Q, 0, LEN_ZERO);
          3'd2: op = mk_op(1, LEN_3Q_16TH, 0, LEN_ZERO);
          3'd4: op = mk_op(-1, LEN_3Q_16TH, 0, LEN_ZERO);
          3'd5: op = mk_op(-6, LEN_3Q, 0, LEN_ZERO);
          default: ;
        endcase
      end
      STYLE_BAR: begin
        case (k)
          3'd0: op = mk_op(0, LEN_31_32, -90, LEN_TWO);
          3'd1: op = mk_op(0, LEN_31_32, 0, LEN_ZERO);
          3'd2: op = mk_op(0, LEN_31_32, 90, LEN_TWO);
          3'd3: op = mk_op(90, LEN_TWO, 0, LEN_ZERO);
          3'd5: op = mk_op(-90, LEN_TWO, 0, LEN_ZERO);
          default: ;
        endcase
      end
      STYLE_BAR_TIP: begin
        case (k)
          3'd0: op = mk_op(-60, LEN_FIVE, 0, LEN_ZERO);
          3'd2: op = mk_op(60, LEN_FIVE, 0, LEN_ZERO);
          3'd3: op = mk_op(60, LEN_FIVE, 0, LEN_3Q);
          3'd4: op = mk_op(0, LEN_31_32, 0, LEN_ZERO);
          3'd5: op = mk_op(-60, LEN_FIVE, 0, LEN_3Q);
          default: ;
        endcase
      end
      STYLE_DIAMOND: begin
        case (k)
          3'd0: op = mk_op(0, LEN_31_32, 0, LEN_ZERO);
          3'd1: op = mk_op(12, LEN_HALF, 0, LEN_ZERO);
          3'd3: op = mk_op(-12, LEN_HALF, 0, LEN_ZERO);
          default: ;
        endcase
      end
      STYLE_DIAMOND_WIDE: begin
        case (k)
          3'd0: op = mk_op(0, LEN_15_16, 0, LEN_ZERO);
          3'd1: op = mk_op(15, LEN_QUARTER, 0, LEN_ZERO);
          3'd3: op = mk_op(-15, LEN_QUARTER, 0, LEN_ZERO);
          default: ;
        endcase
      end
      default: ;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

/* rtl/gnv_front.sv */
// Front end: reading to needle angle (iterative divide, modulo 360 reduction).
`default_nettype none
module gnv_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic signed [15:0] in_reading,
  input  wire gnv_pkg::gnv_cfg_t cfg,
  input  wire logic             q_full,
  output logic                  push,
  output gnv_pkg::ang_t         push_angle
);
  import gnv_pkg::*;

  localparam int DVD_W = 24;
  localparam logic [24:0] WRAP_K = 25'd16777440;  // 360 * 46604
  localparam logic [16:0] RECIP_360 = 17'd93206;  // floor(2^25 / 360)

  logic              acc;
  logic signed [25:0] prod;
  logic [DVD_W-1:0]  mag;
  logic [15:0]       divisor;

  logic              act_r, act_nxt;
  logic              done_r, done_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [16:0]       rem_r, rem_nxt;
  logic              neg_r, neg_nxt;

  logic              hold;
  logic              s1_v_r, s2_v_r;
  logic [24:0]       s1_m_r, s2_m_r;
  logic [15:0]       s2_qh_r;

  logic [DVD_W-1:0]  step_dvd;
  logic [16:0]       step_rem;
  logic signed [24:0] quo, quo_c;
  logic signed [25:0] ang_v;
  logic [41:0]       qprod;
  logic [25:0]       rem360;

  assign hold = s2_v_r && q_full;
  assign busy = act_r || (done_r && hold);
  assign acc  = start && !busy;

  assign divisor = (cfg.full_scale == 16'd0) ? 16'd1 : cfg.full_scale;
  assign prod    = in_reading * $signed({1'b0, cfg.angle_span});
  assign mag     = prod[25] ? DVD_W'(-prod) : DVD_W'(prod);

  // three restoring steps a cycle
  always_comb begin
    step_dvd = dvd_r;
    step_rem = rem_r;
    for (int i = 0; i < 3; i++) begin
      step_rem = {step_rem[15:0], step_dvd[DVD_W-1]};
      if (step_rem >= {1'b0, divisor}) begin
        step_rem = step_rem - {1'b0, divisor};
        step_dvd = {step_dvd[DVD_W-2:0], 1'b1};
      end else begin
        step_dvd = {step_dvd[DVD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    act_nxt  = act_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    if (done_r && !hold) done_nxt = 1'b0;
    if (act_r) begin
      dvd_nxt = step_dvd;
      rem_nxt = step_rem;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
    if (acc) begin
      act_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = mag;
      rem_nxt = '0;
      neg_nxt = prod[25];
    end
  end

  assign quo   = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
  assign quo_c = (quo > $signed({16'd0, cfg.angle_span})) ?
                 $signed({16'd0, cfg.angle_span}) : quo;
  assign ang_v = 26'(cfg.start_angle) + 26'(quo_c) - 26'sd90;

  assign qprod  = s1_m_r * RECIP_360;
  assign rem360 = {1'b0, s2_m_r} - ({10'd0, s2_qh_r} * 26'd360);
  assign push   = s2_v_r && !q_full;
  assign push_angle = (rem360 >= 26'd360) ? 9'(rem360 - 26'd360) : 9'(rem360);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      if (!hold) begin
        s1_v_r <= done_r;
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    if (!hold) begin
      s1_m_r  <= 25'(ang_v) + WRAP_K;
      s2_m_r  <= s1_m_r;
      s2_qh_r <= 16'(qprod >> 25);
    end
  end

endmodule
`default_nettype wire

/* rtl/gnv_queue.sv */
// Four-entry angle queue between front and back.
`default_nettype none
module gnv_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire gnv_pkg::ang_t push_data,
  input  wire logic          pop,
  output gnv_pkg::ang_t      pop_data,
  output logic               full,
  output logic               not_empty
);
  import gnv_pkg::*;

  ang_t       mem_r [0:3];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r;

  assign full      = (cnt_r == 3'd4);
  assign not_empty = (cnt_r != 3'd0);
  assign pop_data  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 2'd1;
      if (pop) rd_r <= rd_r + 2'd1;
      cnt_r <= cnt_r + {2'b00, push} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule
`default_nettype wire

/* rtl/gnv_back.sv */
// Back end: vertex sequencer and three-stage point placement pipeline.
`default_nettype none
module gnv_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gnv_pkg::gnv_cfg_t cfg,
  input  wire logic              q_valid,
  input  wire gnv_pkg::ang_t     q_data,
  output logic                   pop,
  output logic                   out_valid,
  output logic signed [gnv_pkg::COORD_BITS-1:0] out_vertex_x,
  output logic signed [gnv_pkg::COORD_BITS-1:0] out_vertex_y,
  output logic [2:0]             out_vertex_index,
  output logic                   out_last_vertex
);
  import gnv_pkg::*;

  localparam logic signed [POS_W-1:0] SAT_HI = POS_W'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [POS_W-1:0] SAT_LO = -SAT_HI - POS_W'(1);

  vidx_t   n;
  logic    last_k;
  logic    act_r, act_nxt;
  vidx_t   k_r, k_nxt;
  ang_t    base_r, base_nxt;
  vtx_op_t op;

  logic    s1_v_r, s2_v_r;
  vidx_t   s1_k_r, s2_k_r;
  logic    s1_last_r, s2_last_r;
  sin_t    s1_sin1_r, s1_cos1_r, s1_sin2_r, s1_cos2_r;
  len_t    s1_len1_r, s1_len2_r;
  logic signed [PROD_W-1:0] s2_px1_r, s2_py1_r, s2_px2_r, s2_py2_r;

  logic signed [PROD_W-1:0] ny1, ny2;
  logic signed [POS_W-1:0]  px, py;

  assign n      = vtx_count(cfg.needle_style);
  assign last_k = (k_r == n - 3'd1);
  assign pop    = q_valid && (!act_r || last_k);
  // closing vertex repeats the first
  assign op     = vtx_op(cfg.needle_style, last_k ? vidx_t'(0) : k_r);

  always_comb begin
    act_nxt  = act_r;
    k_nxt    = k_r;
    base_nxt = base_r;
    if (act_r) begin
      k_nxt = k_r + 3'd1;
      if (last_k) act_nxt = 1'b0;
    end
    if (pop) begin
      act_nxt  = (n != 3'd0);
      k_nxt    = '0;
      base_nxt = q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      k_r       <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      act_r     <= act_nxt;
      k_r       <= k_nxt;
      s1_v_r    <= act_r;
      s2_v_r    <= s1_v_r;
      out_valid <= s2_v_r;
    end
  end

  assign ny1 = -s2_py1_r;
  assign ny2 = -s2_py2_r;
  assign px  = POS_W'({1'b0, cfg.center_x}) + POS_W'(s2_px1_r >>> SINE_FRAC_BITS)
             + POS_W'(s2_px2_r >>> SINE_FRAC_BITS);
  assign py  = POS_W'({1'b0, cfg.center_y}) + POS_W'(ny1 >>> SINE_FRAC_BITS)
             + POS_W'(ny2 >>> SINE_FRAC_BITS);

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    // stage 1: angles and table lookups
    s1_k_r    <= k_r;
    s1_last_r <= last_k;
    s1_sin1_r <= sine_deg(wrap_small(base_r, op.off1));
    s1_cos1_r <= sine_deg(wrap_small(base_r, op.off1 + off_t'(90)));
    s1_sin2_r <= sine_deg(wrap_small(base_r, op.off2));
    s1_cos2_r <= sine_deg(wrap_small(base_r, op.off2 + off_t'(90)));
    s1_len1_r <= len_value(op.len1, cfg.radius);
    s1_len2_r <= len_value(op.len2, cfg.radius);
    // stage 2: scale by length
    s2_k_r    <= s1_k_r;
    s2_last_r <= s1_last_r;
    s2_px1_r  <= PROD_W'(s1_sin1_r) * $signed(PROD_W'({1'b0, s1_len1_r}));
    s2_py1_r  <= PROD_W'(s1_cos1_r) * $signed(PROD_W'({1'b0, s1_len1_r}));
    s2_px2_r  <= PROD_W'(s1_sin2_r) * $signed(PROD_W'({1'b0, s1_len2_r}));
    s2_py2_r  <= PROD_W'(s1_cos2_r) * $signed(PROD_W'({1'b0, s1_len2_r}));
    // stage 3: floor, offset from pivot, saturate
    out_vertex_index <= s2_k_r;
    out_last_vertex  <= s2_last_r;
    out_vertex_x <= (px > SAT_HI) ? COORD_BITS'(SAT_HI) :
                    (px < SAT_LO) ? COORD_BITS'(SAT_LO) : COORD_BITS'(px);
    out_vertex_y <= (py > SAT_HI) ? COORD_BITS'(SAT_HI) :
                    (py < SAT_LO) ? COORD_BITS'(SAT_LO) : COORD_BITS'(py);
  end

endmodule
`default_nettype wire

/* rtl/gauge_needle_vertex_generator.sv */
// Top level: configuration registers, front end, angle queue and back end.
`default_nettype none
// Each request runs through divider, modulo 360 reduction, angle queue and back end pipeline.
// New requests wait until the 8-step radix-8 divider is done and the queue takes its result;
// the back end emits 5 or 7 vertices per request (none for style 7) at one a cycle.
// The receiver cannot stall: each vertex is on the out_ ports for one cycle with out_valid.
// Reset (rst_n low, synchronous) loads the register defaults and empties every stage.
module gauge_needle_vertex_generator (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic signed [15:0] in_reading,
  output logic                   out_valid,
  output logic signed [gnv_pkg::COORD_BITS-1:0] out_vertex_x,
  output logic signed [gnv_pkg::COORD_BITS-1:0] out_vertex_y,
  output logic [2:0]             out_vertex_index,
  output logic                   out_last_vertex,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import gnv_pkg::*;

  gnv_cfg_t cfg_r;
  logic     q_full, q_valid, q_push, q_pop;
  ang_t     q_in, q_out;

  // register port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x     <= 12'd150;
      cfg_r.center_y     <= 12'd150;
      cfg_r.radius       <= 10'd100;
      cfg_r.start_angle  <= 10'sd30;
      cfg_r.angle_span   <= 9'd180;
      cfg_r.full_scale   <= 16'd100;
      cfg_r.needle_style <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:     cfg_r.center_x    <= cfg_data[11:0];
        REG_CENTER_Y:     cfg_r.center_y    <= cfg_data[11:0];
        REG_RADIUS:       cfg_r.radius      <= cfg_data[9:0];
        REG_START_ANGLE:  cfg_r.start_angle <= $signed(cfg_data[9:0]);
        // span saturates at a full turn
        REG_ANGLE_SPAN:   cfg_r.angle_span  <= (cfg_data[8:0] > 9'd360) ? 9'd360
                                                                        : cfg_data[8:0];
        REG_FULL_SCALE:   cfg_r.full_scale  <= cfg_data;
        REG_NEEDLE_STYLE: cfg_r.needle_style <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // front: needle angle, reduced to 0..359
  gnv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_reading (in_reading),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push       (q_push),
    .push_angle (q_in)
  );

  gnv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .not_empty (q_valid)
  );

  // back: one vertex per cycle, unknown style emits nothing
  gnv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_data           (q_out),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_vertex_index (out_vertex_index),
    .out_last_vertex  (out_last_vertex)
  );

endmodule
`default_nettype wire

/* bench/gnv_checker.sv */
// Vertex predictor and result checker for the gauge needle vertex generator.
`timescale 1ns / 100ps
module gnv_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [15:0] in_reading,
  input  wire logic               out_valid,
  input  wire logic signed [13:0] out_vertex_x,
  input  wire logic signed [13:0] out_vertex_y,
  input  wire logic [2:0]         out_vertex_index,
  input  wire logic               out_last_vertex,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      mismatches,
  output int                      vertices_owed
);
  import gnv_pkg::*;

  localparam int FRAC = 14;
  localparam longint unsigned PI_FIX = 64'd3373259426;

  typedef struct {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic [2:0]         idx;
    logic               last;
  } vertex_t;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  vertex_t   vertex_q[$];
  longint    sine_lut[0:90];
  int        cx, cy, rad, ang0, span, fscale, style;

  initial begin
    mismatches = 0;
    for (int d = 0; d <= 90; d++) sine_lut[d] = quadrant_sine(d);
  end

  always_comb vertices_owed = vertex_q.size();

  function automatic longint quadrant_sine(int d);
    longint unsigned x, x2, t;
    longint          acc;
    x   = (longint'(d) * PI_FIX + 64'd90) / 64'd180;
    x2  = (x * x) >> 30;
    t   = x;
    acc = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2) acc -= longint'(t);
      else acc += longint'(t);
    end
    if (acc < 0) acc = 0;
    return (acc + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  function automatic longint sine_of(int a);
    int d;
    d = a % 360;
    if (d < 0) d += 360;
    if (d <= 90) return sine_lut[d];
    if (d <= 180) return sine_lut[180 - d];
    if (d <= 270) return -sine_lut[d - 180];
    return -sine_lut[360 - d];
  endfunction

  function automatic point_t offset_pt(point_t b, int a, longint len);
    point_t p;
    p.x = ((b.x <<< FRAC) + sine_of(a) * len) >>> FRAC;
    p.y = ((b.y <<< FRAC) - sine_of(a + 90) * len) >>> FRAC;
    return p;
  endfunction

  function automatic logic signed [13:0] clip14(longint v);
    if (v > 8191) v = 8191;
    if (v < -8192) v = -8192;
    return 14'(v);
  endfunction

  // Work out the whole outline for one reading and queue its vertices
  task automatic predict_outline(int rd);
    int     a, cap, fs, n;
    longint r, r34;
    point_t c, q, p[7];
    vertex_t v;
    fs  = (fscale == 0) ? 1 : fscale;
    a   = ang0 + (rd * span) / fs;
    cap = ang0 + span;
    if (a > cap) a = cap;
    a  -= 90;
    r   = rad;
    r34 = r - (r >> 2);
    c.x = cx;
    c.y = cy;
    n   = 0;
    case (style)
      STYLE_KITE: begin
        p[0] = offset_pt(c, a, r);
        p[1] = offset_pt(c, a + 90, r >> 5);
        p[2] = offset_pt(c, a + 180, r >> 5);
        p[3] = offset_pt(c, a + 270, r >> 5);
        n = 5;
      end
      STYLE_SPEAR: begin
        p[0] = offset_pt(c, a, r);
        p[1] = offset_pt(c, a + 4, r34);
        p[2] = c;
        p[3] = offset_pt(c, a - 4, r34);
        n = 5;
      end
      STYLE_ARROW: begin
        p[0] = offset_pt(c, a, r);
        p[1] = offset_pt(c, a + 6, r34);
        p[2] = offset_pt(c, a + 1, r34 + (r >> 4));
        p[3] = c;
        p[4] = offset_pt(c, a - 1, r34 + (r >> 4));
        p[5] = offset_pt(c, a - 6, r34);
        n = 7;
      end
      STYLE_BAR: begin
        q    = offset_pt(c, a, r - (r >> 5));
        p[0] = offset_pt(q, a - 90, 2);
        p[1] = q;
        p[2] = offset_pt(q, a + 90, 2);
        p[3] = offset_pt(c, a + 90, 2);
        p[4] = c;
        p[5] = offset_pt(c, a - 90, 2);
        n = 7;
      end
      STYLE_BAR_TIP: begin
        q    = offset_pt(c, a, r - (r >> 5));
        p[0] = offset_pt(c, a - 60, 5);
        p[1] = c;
        p[2] = offset_pt(c, a + 60, 5);
        p[3] = offset_pt(p[2], a, r34);
        p[4] = q;
        p[5] = offset_pt(p[0], a, r34);
        n = 7;
      end
      STYLE_DIAMOND: begin
        p[0] = offset_pt(c, a, r - (r >> 5));
        p[1] = offset_pt(c, a + 12, r - (r >> 1));
        p[2] = c;
        p[3] = offset_pt(c, a - 12, r - (r >> 1));
        n = 5;
      end
      STYLE_DIAMOND_WIDE: begin
        p[0] = offset_pt(c, a, (r * 15) >> 4);
        p[1] = offset_pt(c, a + 15, (r * 4) >> 4);
        p[2] = c;
        p[3] = offset_pt(c, a - 15, (r * 4) >> 4);
        n = 5;
      end
      default: n = 0;  // style 7 draws nothing
    endcase
    if (n > 0) p[n - 1] = p[0];
    for (int k = 0; k < n; k++) begin
      v.x    = clip14(p[k].x);
      v.y    = clip14(p[k].y);
      v.idx  = 3'(k);
      v.last = (k == n - 1);
      vertex_q.push_back(v);
    end
  endtask

  task automatic report(string what);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      cx = 150; cy = 150; rad = 100; ang0 = 30;
      span = 180; fscale = 100; style = STYLE_SPEAR;
      vertex_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X:     cx = cfg_data[11:0];
          REG_CENTER_Y:     cy = cfg_data[11:0];
          REG_RADIUS:       rad = cfg_data[9:0];
          REG_START_ANGLE:  ang0 = $signed(cfg_data[9:0]);
          REG_ANGLE_SPAN:   span = (cfg_data[8:0] > 360) ? 360 : cfg_data[8:0];
          REG_FULL_SCALE:   fscale = cfg_data;
          REG_NEEDLE_STYLE: style = cfg_data[2:0];
          default: ;       // index 7: no register
        endcase
      end
      if (start && !busy) predict_outline(in_reading);
      if (out_valid) begin
        if (vertex_q.size() == 0) begin
          report($sformatf("unexpected vertex idx %0d", out_vertex_index));
        end else begin
          e = vertex_q.pop_front();
          if (out_vertex_x !== e.x)
            report($sformatf("x got %0d exp %0d", out_vertex_x, e.x));
          if (out_vertex_y !== e.y)
            report($sformatf("y got %0d exp %0d", out_vertex_y, e.y));
          if (out_vertex_index !== e.idx)
            report($sformatf("index got %0d exp %0d", out_vertex_index, e.idx));
          if (out_last_vertex !== e.last)
            report($sformatf("last got %0b exp %0b", out_last_vertex, e.last));
        end
      end
    end
  end
endmodule

/* bench/tb.sv */
// Top of the gauge needle vertex generator bench: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb;
  import gnv_pkg::*;

  localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all
  localparam int SETTLE      = 30;     // longer than the latency to the first vertex plus a full outline

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_reading = '0;
  logic               out_valid;
  logic signed [13:0] out_vertex_x, out_vertex_y;
  logic [2:0]         out_vertex_index;
  logic               out_last_vertex;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 mismatches, vertices_owed;
  int                 requests_sent = 0, vertices_seen = 0, idle_cycles = 0;

  always #6 clk = ~clk;

  gauge_needle_vertex_generator dut (
    .clk, .rst_n, .start, .busy, .in_reading,
    .out_valid, .out_vertex_x, .out_vertex_y, .out_vertex_index, .out_last_vertex,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  gnv_checker chk (
    .clk, .rst_n, .start, .busy, .in_reading,
    .out_valid, .out_vertex_x, .out_vertex_y, .out_vertex_index, .out_last_vertex,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .vertices_owed
  );

  // Watchdog: any accepted request, config write or vertex resets the count
  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (out_valid) vertices_seen <= vertices_seen + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One reading: random gap, then hold start until busy is seen low.
  // A zero gap keeps start high straight into the next request.
  task automatic send_reading(logic signed [15:0] rd);
    int  gap;
    bit  taken;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    in_reading = rd;
    taken      = 1'b0;
    while (!taken) begin
      taken = !busy;          // busy only moves at the rising edge
      @(negedge clk);
    end
    requests_sent++;
    if ($urandom_range(0, 3) != 0) start = 1'b0;
  endtask

  // Config writes only once the block has drained; style 7 leaves no trace,
  // so a fixed settle covers a request still in flight.
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    bit taken;
    start = 1'b0;
    while (vertices_owed != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    taken     = 1'b0;
    while (!taken) begin
      taken = cfg_ready;
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  // Readings that hit zero, the cap, negatives and the full 16-bit range
  function automatic logic signed [15:0] pick_reading(int fs);
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 65535));
      1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2:       return -16'sd1 * 16'($urandom_range(0, 200));
      default: return 16'($urandom_range(0, (fs > 32767 || fs == 0) ? 32767 : fs + 5));
    endcase
  endfunction

  initial begin
    int fs;
    logic signed [15:0] edge_reads [6] = '{16'sd0, 16'sd100, 16'sd50,
                                           16'sh7fff, 16'sh8000, -16'sd1};
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings with boundary readings
    foreach (edge_reads[i]) send_reading(edge_reads[i]);

    // Every style once, including the one that draws nothing
    for (int s = STYLE_KITE; s <= 7; s++) begin
      write_reg(REG_NEEDLE_STYLE, 16'(s));
      send_reading(16'sd37);
      send_reading(16'sd100);
    end

    // Extreme registers: corner pivots, zero and full radius, clamped span,
    // zero full scale, out-of-range index
    write_reg(REG_CENTER_X, 16'hffff);
    write_reg(REG_CENTER_Y, 16'h0000);
    write_reg(REG_RADIUS, 16'h03ff);
    write_reg(REG_START_ANGLE, 16'(-360));
    write_reg(REG_ANGLE_SPAN, 16'h01ff);
    write_reg(REG_FULL_SCALE, 16'h0000);
    write_reg(REG_NEEDLE_STYLE, 16'(STYLE_BAR_TIP));
    write_reg(3'd7, 16'hffff);
    send_reading(16'sh7fff);
    send_reading(16'sh8000);
    write_reg(REG_RADIUS, 16'h0000);
    write_reg(REG_START_ANGLE, 16'sd360);
    write_reg(REG_FULL_SCALE, 16'hffff);
    write_reg(REG_ANGLE_SPAN, 16'd0);
    send_reading(16'sh7fff);
    send_reading(16'sd0);

    // Random phases: fresh settings, mostly valid styles, then readings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_CENTER_X, 16'($urandom));
      write_reg(REG_CENTER_Y, 16'($urandom));
      write_reg(REG_RADIUS, 16'($urandom));
      write_reg(REG_START_ANGLE, $urandom_range(0, 1) ?
                16'($urandom_range(0, 720) - 360) : 16'($urandom));
      write_reg(REG_ANGLE_SPAN, 16'($urandom));
      fs = $urandom_range(0, 2) ? $urandom_range(1, 300) : $urandom_range(0, 65535);
      write_reg(REG_FULL_SCALE, 16'(fs));
      write_reg(REG_NEEDLE_STYLE, 16'($urandom_range(0, 9) == 0 ? 7 : $urandom_range(0, 6)));
      if ($urandom_range(0, 3) == 0) write_reg(3'd7, 16'($urandom));
      repeat (20) send_reading(pick_reading(fs));
    end

    start = 1'b0;
    while (vertices_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d readings, %0d vertices, all styles and register extremes",
             requests_sent, vertices_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches found", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/gnv_pkg.sv
rtl/gnv_front.sv
rtl/gnv_queue.sv
rtl/gnv_back.sv
rtl/gauge_needle_vertex_generator.sv
bench/gnv_checker.sv
bench/tb.sv
